/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ccw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ccw_pkg;

	localparam int MAX_AMOUNT  = 1023;
	localparam int AMOUNT_W    = 10;
	localparam int COIN_W      = 10;
	localparam int COIN_COUNT  = 4;
	localparam int COIN_SEL_W  = $clog2(COIN_COUNT);
	localparam int CFG_INDEX_W = 3;
	localparam int WAYS_W      = 32;
	localparam int TABLE_DEPTH = MAX_AMOUNT + 1;
	localparam int ADDR_W      = AMOUNT_W;
	localparam int STEP_W      = 4;

	localparam logic [WAYS_W-1:0] WAYS_MAX = {WAYS_W{1'b1}};

	localparam logic [COIN_W-1:0] COIN_A_RESET = COIN_W'(25);
	localparam logic [COIN_W-1:0] COIN_B_RESET = COIN_W'(10);
	localparam logic [COIN_W-1:0] COIN_C_RESET = COIN_W'(5);
	localparam logic [COIN_W-1:0] COIN_D_RESET = COIN_W'(1);

	localparam logic [CFG_INDEX_W-1:0] REG_COIN_A = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_COIN_B = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_COIN_C = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_COIN_D = CFG_INDEX_W'(3);

	localparam logic [COIN_SEL_W-1:0] SEL_A = COIN_SEL_W'(0);
	localparam logic [COIN_SEL_W-1:0] SEL_B = COIN_SEL_W'(1);
	localparam logic [COIN_SEL_W-1:0] SEL_C = COIN_SEL_W'(2);
	localparam logic [COIN_SEL_W-1:0] SEL_D = COIN_SEL_W'(3);

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [COIN_COUNT-1:0][COIN_W-1:0] coin_arr_t;

	typedef enum logic [2:0] {
		OP_ACCEPT,
		OP_CLEAR,
		OP_LOAD,
		OP_SWEEP,
		OP_FETCH,
		OP_EMIT
	} op_t;

	// One control word. The jump is taken when the condition of the op holds;
	// otherwise the step holds or advances.
	typedef struct packed {
		op_t                   op;
		logic [COIN_SEL_W-1:0] coin_sel;
		logic                  hold;
		step_t                 jump;
	} ucode_t;

	typedef struct packed {
		logic in_xfer;
		logic at_end;
		logic skip;
		logic out_free;
	} cond_t;

	localparam step_t STEP_ACCEPT = STEP_W'(0);
	localparam step_t STEP_CLEAR  = STEP_W'(1);
	localparam step_t STEP_LOAD_A = STEP_W'(2);
	localparam step_t STEP_LOAD_B = STEP_W'(4);
	localparam step_t STEP_LOAD_C = STEP_W'(6);
	localparam step_t STEP_LOAD_D = STEP_W'(8);
	localparam step_t STEP_FETCH  = STEP_W'(10);

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		case (step)
			STEP_W'(0):  w = '{OP_ACCEPT, SEL_A, 1'b1, STEP_CLEAR};
			STEP_W'(1):  w = '{OP_CLEAR,  SEL_A, 1'b1, STEP_LOAD_A};
			STEP_W'(2):  w = '{OP_LOAD,   SEL_A, 1'b0, STEP_LOAD_B};
			STEP_W'(3):  w = '{OP_SWEEP,  SEL_A, 1'b1, STEP_LOAD_B};
			STEP_W'(4):  w = '{OP_LOAD,   SEL_B, 1'b0, STEP_LOAD_C};
			STEP_W'(5):  w = '{OP_SWEEP,  SEL_B, 1'b1, STEP_LOAD_C};
			STEP_W'(6):  w = '{OP_LOAD,   SEL_C, 1'b0, STEP_LOAD_D};
			STEP_W'(7):  w = '{OP_SWEEP,  SEL_C, 1'b1, STEP_LOAD_D};
			STEP_W'(8):  w = '{OP_LOAD,   SEL_D, 1'b0, STEP_FETCH};
			STEP_W'(9):  w = '{OP_SWEEP,  SEL_D, 1'b1, STEP_FETCH};
			STEP_W'(10): w = '{OP_FETCH,  SEL_A, 1'b0, STEP_ACCEPT};
			STEP_W'(11): w = '{OP_EMIT,   SEL_A, 1'b1, STEP_ACCEPT};
			default:     w = '{OP_ACCEPT, SEL_A, 1'b1, STEP_CLEAR};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* hdl/ccw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Way table: one write port and two registered read ports. A read of the
// address being written in the same cycle returns the new data.
module ccw_ram (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [ccw_pkg::ADDR_W-1:0]     waddr,
	input  wire logic [ccw_pkg::WAYS_W-1:0]     wdata,
	input  wire logic [ccw_pkg::ADDR_W-1:0]     ra_addr,
	input  wire logic [ccw_pkg::ADDR_W-1:0]     rb_addr,
	output logic      [ccw_pkg::WAYS_W-1:0]     ra_data,
	output logic      [ccw_pkg::WAYS_W-1:0]     rb_data
);

	logic [ccw_pkg::WAYS_W-1:0] mem_q [ccw_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		ra_data <= (we && waddr == ra_addr) ? wdata : mem_q[ra_addr];
		rb_data <= (we && waddr == rb_addr) ? wdata : mem_q[rb_addr];
	end

endmodule

`default_nettype wire

/* hdl/ccw_ucode.sv */
`timescale 1ns / 1ps
`default_nettype none

module ccw_ucode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ccw_pkg::cond_t  cond,
	output ccw_pkg::ucode_t      ctrl
);

	ccw_pkg::step_t step_q;
	ccw_pkg::step_t step_next;
	logic           take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ccw_pkg::STEP_ACCEPT;
		end else begin
			step_q <= step_next;
		end
	end

	always_comb begin
		ctrl = ccw_pkg::ucode_rom(step_q);
		case (ctrl.op)
			ccw_pkg::OP_ACCEPT: take = cond.in_xfer;
			ccw_pkg::OP_CLEAR:  take = cond.at_end;
			ccw_pkg::OP_LOAD:   take = cond.skip;
			ccw_pkg::OP_SWEEP:  take = cond.at_end;
			ccw_pkg::OP_EMIT:   take = cond.out_free;
			default:            take = 1'b0;
		endcase
		if (take) begin
			step_next = ctrl.jump;
		end else if (ctrl.hold) begin
			step_next = step_q;
		end else begin
			step_next = step_q + ccw_pkg::STEP_W'(1);
		end
	end

endmodule

`default_nettype wire

/* hdl/ccw_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ccw_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ccw_pkg::ucode_t                 ctrl,
	input  wire ccw_pkg::coin_arr_t              coins,
	input  wire logic                            in_valid,
	input  wire logic [ccw_pkg::AMOUNT_W-1:0]    amount,
	input  wire logic                            out_stall,
	output ccw_pkg::cond_t                       cond,
	output logic                                 in_stall,
	output logic                                 out_valid,
	output logic      [ccw_pkg::WAYS_W-1:0]      ways,
	output logic                                 saturated
);

	logic [ccw_pkg::AMOUNT_W-1:0] amount_q;
	logic [ccw_pkg::AMOUNT_W-1:0] j_q;
	logic [ccw_pkg::COIN_W-1:0]   coin_q;
	logic                         sat_q;
	logic                         sweep_s1;
	logic [ccw_pkg::ADDR_W-1:0]   addr_s1;
	logic                         out_valid_q;
	logic [ccw_pkg::WAYS_W-1:0]   ways_q;
	logic                         out_sat_q;

	logic [ccw_pkg::COIN_W-1:0]   coin_sel_val;
	logic                         emit;
	logic                         we;
	logic [ccw_pkg::ADDR_W-1:0]   waddr;
	logic [ccw_pkg::WAYS_W-1:0]   wdata;
	logic [ccw_pkg::ADDR_W-1:0]   ra_addr;
	logic [ccw_pkg::ADDR_W-1:0]   rb_addr;
	logic [ccw_pkg::WAYS_W-1:0]   ra_data;
	logic [ccw_pkg::WAYS_W-1:0]   rb_data;
	logic [ccw_pkg::WAYS_W:0]     sum;

	ccw_ram u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.ra_addr (ra_addr),
		.rb_addr (rb_addr),
		.ra_data (ra_data),
		.rb_data (rb_data)
	);

	always_comb begin
		coin_sel_val  = coins[ctrl.coin_sel];
		in_stall      = (ctrl.op != ccw_pkg::OP_ACCEPT);
		cond.in_xfer  = in_valid && !in_stall;
		cond.at_end   = (j_q == amount_q);
		cond.skip     = (coin_sel_val == '0) || (coin_sel_val > amount_q);
		cond.out_free = !out_valid_q || !out_stall;
		emit          = (ctrl.op == ccw_pkg::OP_EMIT) && cond.out_free;

		sum = {1'b0, ra_data} + {1'b0, rb_data};

		if (ctrl.op == ccw_pkg::OP_CLEAR) begin
			we    = 1'b1;
			waddr = j_q;
			wdata = (j_q == '0) ? ccw_pkg::WAYS_W'(1) : '0;
		end else begin
			we    = sweep_s1;
			waddr = addr_s1;
			wdata = sum[ccw_pkg::WAYS_W] ? ccw_pkg::WAYS_MAX : sum[ccw_pkg::WAYS_W-1:0];
		end

		if (ctrl.op == ccw_pkg::OP_SWEEP) begin
			ra_addr = j_q;
			rb_addr = j_q - coin_q;
		end else begin
			ra_addr = amount_q;
			rb_addr = amount_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sweep_s1 <= (ctrl.op == ccw_pkg::OP_SWEEP);
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= j_q;
		case (ctrl.op)
			ccw_pkg::OP_ACCEPT: begin
				if (cond.in_xfer) begin
					amount_q <= amount;
					j_q      <= '0;
					sat_q    <= 1'b0;
				end
			end
			ccw_pkg::OP_CLEAR: begin
				j_q <= j_q + ccw_pkg::AMOUNT_W'(1);
			end
			ccw_pkg::OP_LOAD: begin
				coin_q <= coin_sel_val;
				j_q    <= coin_sel_val;
			end
			ccw_pkg::OP_SWEEP: begin
				j_q <= j_q + ccw_pkg::AMOUNT_W'(1);
			end
			default: begin
			end
		endcase
		if (sweep_s1 && sum[ccw_pkg::WAYS_W]) begin
			sat_q <= 1'b1;
		end
		if (emit) begin
			ways_q    <= ra_data;
			out_sat_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ways      = ways_q;
	assign saturated = out_sat_q;

endmodule

`default_nettype wire

/* hdl/coin_change_way_counter.sv */
// Channel   Handshake              Payload
// input     in_valid / in_stall    amount
// output    out_valid / out_stall  ways, saturated
// config    cfg_we                 cfg_index, cfg_data
//
// One request clears the table up to amount, then sweeps it once for each
// nonzero coin not above amount, writing one table entry a cycle through
// the single write port of the way table.
// Reset clears the sequencer and the output valid; the table needs no clearing.
// A stalled result sits in the output register while the next amount is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module coin_change_way_counter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ccw_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [ccw_pkg::COIN_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [ccw_pkg::AMOUNT_W-1:0]       amount,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [ccw_pkg::WAYS_W-1:0]         ways,
	output logic                                    saturated
);

	ccw_pkg::coin_arr_t coins_q;
	ccw_pkg::ucode_t    ctrl;
	ccw_pkg::cond_t     cond;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coins_q[ccw_pkg::SEL_A] <= ccw_pkg::COIN_A_RESET;
			coins_q[ccw_pkg::SEL_B] <= ccw_pkg::COIN_B_RESET;
			coins_q[ccw_pkg::SEL_C] <= ccw_pkg::COIN_C_RESET;
			coins_q[ccw_pkg::SEL_D] <= ccw_pkg::COIN_D_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ccw_pkg::REG_COIN_A: coins_q[ccw_pkg::SEL_A] <= cfg_data;
				ccw_pkg::REG_COIN_B: coins_q[ccw_pkg::SEL_B] <= cfg_data;
				ccw_pkg::REG_COIN_C: coins_q[ccw_pkg::SEL_C] <= cfg_data;
				ccw_pkg::REG_COIN_D: coins_q[ccw_pkg::SEL_D] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ccw_ucode u_ucode (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctrl   (ctrl)
	);

	ccw_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.coins     (coins_q),
		.in_valid  (in_valid),
		.amount    (amount),
		.out_stall (out_stall),
		.cond      (cond),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.ways      (ways),
		.saturated (saturated)
	);

	`ASSERT_NEXT(a_accept_clears, in_valid && !in_stall, ctrl.op == ccw_pkg::OP_CLEAR,
		"accepted amount did not start the table clear")
	`ASSERT_NEXT(a_emit_valid, ctrl.op == ccw_pkg::OP_EMIT && cond.out_free, out_valid,
		"result step did not present a result")
	`ASSERT_SAME(a_busy_stalls, ctrl.op == ccw_pkg::OP_SWEEP || ctrl.op == ccw_pkg::OP_CLEAR,
		in_stall, "input taken while the table is in use")

endmodule

`default_nettype wire
